[src/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_FULL,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic        [15:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [15:0] out_priority;
        status_t            status;
        logic        [4:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
        logic        [15:0] priority_req;
    } job_t;

endpackage

[src/spq_front.sv]
// Front part of the sorted priority queue: takes command beats and classifies them.
// Depends on spq_pkg; feeds spq_fifo.
`timescale 1ns / 1ps

module spq_front #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spq_pkg::cmd_t cmd,
    input  logic          queue_full,
    output logic          push,
    output spq_pkg::job_t job
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push = start && !queue_full;

    always_comb
    begin
        count_next       = count_reg;
        job.value        = cmd.value;
        job.priority_req = cmd.priority_req;
        job.op           = OP_ENQ;
        unique case (cmd.mode)
            MODE_ENQ:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    job.op = OP_FULL;
                end
                else
                begin
                    job.op     = OP_ENQ;
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    job.op = OP_EMPTY;
                end
                else
                begin
                    job.op     = OP_DEQ;
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

[src/spq_fifo.sv]
// Two-entry queue that decouples the front and back parts.
// Depends on spq_pkg only by convention; carries an opaque word.
`timescale 1ns / 1ps

module spq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    import spq_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/spq_back.sv]
// Back part of the sorted priority queue: a sorted chain of entry cells and the result register.
// Depends on spq_pkg; fed by spq_fifo.
`timescale 1ns / 1ps

module spq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  spq_pkg::job_t job,
    output logic          pop,
    output logic          done,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic signed [31:0] val_reg [QUEUE_DEPTH];
    logic signed [31:0] val_next [QUEUE_DEPTH];
    logic        [15:0] pri_reg [QUEUE_DEPTH];
    logic        [15:0] pri_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [QUEUE_DEPTH-1:0] keep;
    logic [CNT_W+4:0]   occ_ext;
    logic               done_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    assign pop     = job_valid;
    assign done    = done_reg;
    assign rsp     = rsp_reg;
    assign occ_ext = {5'd0, count_next};

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] <= job.priority_req);
        end
    end

    always_comb
    begin
        val_next   = val_reg;
        pri_next   = pri_reg;
        count_next = count_reg;
        unique case (job.op)
            OP_ENQ:
            begin
                if (!keep[0])
                begin
                    val_next[0] = job.value;
                    pri_next[0] = job.priority_req;
                end
                for (int i = 1; i < QUEUE_DEPTH; i++)
                begin
                    if (!keep[i])
                    begin
                        if (keep[i-1])
                        begin
                            val_next[i] = job.value;
                            pri_next[i] = job.priority_req;
                        end
                        else
                        begin
                            val_next[i] = val_reg[i-1];
                            pri_next[i] = pri_reg[i-1];
                        end
                    end
                end
                count_next = count_reg + 1'b1;
            end
            OP_DEQ:
            begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    val_next[i] = val_reg[i+1];
                    pri_next[i] = pri_reg[i+1];
                end
                count_next = count_reg - 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.out_value    = '0;
        rsp_next.out_priority = '0;
        rsp_next.occupancy    = occ_ext[4:0];
        unique case (job.op)
            OP_DEQ:
            begin
                rsp_next.out_value    = val_reg[0];
                rsp_next.out_priority = pri_reg[0];
                rsp_next.status       = ST_DONE;
            end
            OP_FULL:  rsp_next.status = ST_FULL;
            OP_EMPTY: rsp_next.status = ST_EMPTY;
            default:  rsp_next.status = ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= job_valid;
            if (job_valid)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            val_reg <= val_next;
            pri_reg <= pri_next;
            rsp_reg <= rsp_next;
        end
    end

endmodule

[src/sorted_priority_queue.sv]
// Top level of the sorted priority queue: front classifier, decoupling queue, sorted cell chain.
// Depends on spq_pkg, spq_front, spq_fifo and spq_back.
`timescale 1ns / 1ps
//
//  Channel   Signals               Direction  Beat taken when
//  command   start, busy, cmd      in         start && !busy at a rising edge
//  result    done, rsp             out        done is high for one cycle
//
//  Each command beat yields one result beat via the queue entry and the result register.
//  A new command can be taken in every cycle while busy is low; the back part's cell chain
//  inserts or removes one entry per cycle with all cells updated in parallel.
//  Reset clears the entry count, the queue and the strobe; entry cells are not cleared.
//  The receiver cannot stall; busy rises only when the decoupling queue is full.

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spq_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int JOB_W = $bits(job_t);

    logic             push;
    logic             pop;
    logic             fifo_full;
    logic             fifo_empty;
    job_t             push_job;
    job_t             pop_job;
    logic [JOB_W-1:0] fifo_rd_data;

    assign busy    = fifo_full;
    assign pop_job = job_t'(fifo_rd_data);

    spq_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .queue_full (fifo_full),
        .push       (push),
        .job        (push_job)
    );

    spq_fifo #(
        .WIDTH(JOB_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_job),
        .rd_en   (pop),
        .rd_data (fifo_rd_data),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    spq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!fifo_empty),
        .job       (pop_job),
        .pop       (pop),
        .done      (done),
        .rsp       (rsp)
    );

    a_done_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop))
        else $error("Result strobe without a job taken from the queue.");

    a_flag_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_DONE) |-> (rsp.out_value == '0 && rsp.out_priority == '0))
        else $error("Flagged result carries a nonzero payload.");

    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("Command beat did not produce a result two cycles later.");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the sorted priority queue: directed and random command beats.
// Depends on spq_pkg and sorted_priority_queue; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 1000;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic done;
    rsp_t rsp;

    sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    class spq_scoreboard;
        logic signed [31:0] held_value[DEPTH];
        logic        [15:0] held_prio[DEPTH];
        int                 held_count;
        rsp_t               awaited[$];
        int                 errors;
        int                 cmds_taken;
        int                 results_seen;
        int                 full_drops;
        int                 empty_pops;
        int                 peak_count;

        function new();
            held_count   = 0;
            errors       = 0;
            cmds_taken   = 0;
            results_seen = 0;
            full_drops   = 0;
            empty_pops   = 0;
            peak_count   = 0;
        endfunction

        function void note_command(cmd_t c);
            rsp_t e;
            int   pos;
            e = '0;
            e.status = ST_DONE;
            cmds_taken++;
            if (c.mode == MODE_ENQ) begin
                if (held_count >= DEPTH) begin
                    e.status = ST_FULL;
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= c.priority_req)
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_value[i] = held_value[i - 1];
                        held_prio[i]  = held_prio[i - 1];
                    end
                    held_value[pos] = c.value;
                    held_prio[pos]  = c.priority_req;
                    held_count++;
                    if (held_count > peak_count)
                        peak_count = held_count;
                end
            end else begin
                if (held_count == 0) begin
                    e.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    e.out_value    = held_value[0];
                    e.out_priority = held_prio[0];
                    for (int i = 1; i < held_count; i++) begin
                        held_value[i - 1] = held_value[i];
                        held_prio[i - 1]  = held_prio[i];
                    end
                    held_count--;
                end
            end
            e.occupancy = 5'(held_count);
            awaited.push_back(e);
        endfunction

        task report_mismatch(string what, longint expected, longint got);
            errors++;
            $display("MISMATCH result %0d %s: expected %0h, got %0h",
                     results_seen, what, expected, got);
        endtask

        task check_result(rsp_t got);
            rsp_t e;
            results_seen++;
            if (awaited.size() == 0) begin
                report_mismatch("arrived with nothing awaited", 64'd0, longint'(got));
                return;
            end
            e = awaited.pop_front();
            if (got.out_value !== e.out_value)
                report_mismatch("out_value", longint'(e.out_value),
                                longint'(got.out_value));
            if (got.out_priority !== e.out_priority)
                report_mismatch("out_priority", longint'(e.out_priority),
                                longint'(got.out_priority));
            if (got.status !== e.status)
                report_mismatch("status", longint'(e.status), longint'(got.status));
            if (got.occupancy !== e.occupancy)
                report_mismatch("occupancy", longint'(e.occupancy),
                                longint'(got.occupancy));
        endtask
    endclass

    spq_scoreboard sb;
    int            quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_command(cmd);
            if (done)
                sb.check_result(rsp);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat taken for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(cmd_t c);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_one();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain_results();
        idle_one();
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_t make_cmd(int pop_pct);
        cmd_t c;
        c.mode  = ($urandom_range(99) < pop_pct) ? MODE_DEQ : MODE_ENQ;
        c.value = $urandom;
        case ($urandom_range(3))
            0: c.priority_req = 16'($urandom_range(3));
            1: c.priority_req = 16'($urandom);
            2: c.priority_req = $urandom_range(1) ? 16'hffff : 16'h0000;
            default: c.priority_req = 16'($urandom_range(15));
        endcase
        return c;
    endfunction

    initial begin
        cmd_t c;
        int   idle_pct[4];
        int   pop_pct;
        sb = new();
        idle_pct = '{0, 63, 0, 35};
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: pop from empty, fill with extreme values and tied priorities,
        // push once more while full, then pop a few.
        c = make_cmd(100);
        send_beat(c);
        for (int i = 0; i < DEPTH; i++) begin
            c.mode = MODE_ENQ;
            case (i % 4)
                0: begin c.value = 32'sh7fffffff; c.priority_req = 16'h0000; end
                1: begin c.value = 32'sh80000000; c.priority_req = 16'hffff; end
                2: begin c.value = 32'sh55555555 ^ i; c.priority_req = 16'h5555; end
                default: begin c.value = 32'shaaaaaaaa ^ i; c.priority_req = 16'haaaa; end
            endcase
            send_beat(c);
        end
        c.mode = MODE_ENQ;
        c.value = -32'sd1;
        c.priority_req = 16'h0000;
        send_beat(c);
        repeat (7)
        begin
            c = make_cmd(100);
            send_beat(c);
        end
        drain_results();

        // Random part in four phases of sender idling; bias toward pushes or pops
        // changes every 40 beats so the queue swings between empty and full.
        for (int ph = 0; ph < 4; ph++) begin
            for (int blk = 0; blk < 8; blk++) begin
                case ($urandom_range(2))
                    0: pop_pct = 20;
                    1: pop_pct = 50;
                    default: pop_pct = 80;
                endcase
                for (int n = 0; n < 40; n++) begin
                    while ($urandom_range(99) < idle_pct[ph])
                        idle_one();
                    send_beat(make_cmd(pop_pct));
                end
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d command beats and %0d result beats over four idling phases.",
                 sb.cmds_taken, sb.results_seen);
        $display("Dropped pushes while full: %0d, pops while empty: %0d, peak occupancy: %0d.",
                 sb.full_drops, sb.empty_pops, sb.peak_count);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
